[src/mandelbrot_escape_time_colour_assert.svh]
// ----------------------------------------------------------------------------
// mandelbrot escape time colour assertion macros
// shared property wrappers, clocked on i_clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_TIME_COLOUR_ASSERT_SVH
`define MANDELBROT_ESCAPE_TIME_COLOUR_ASSERT_SVH

// same-cycle implication
`define MET_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MET_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/met_pkg.sv]
// ----------------------------------------------------------------------------
// met_pkg
// types, constants and helper functions of the escape time colour block
// ----------------------------------------------------------------------------
package met_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 28;
    localparam int CNT_WIDTH   = 7;
    localparam int COL_WIDTH   = 8;
    localparam int PROD_WIDTH  = 2 * COORD_WIDTH;

    localparam logic [CNT_WIDTH-1:0] MAX_ITER_RST = 7'd127;

    // |z|^2 escape bound, 4.0 at double fraction width
    localparam logic [PROD_WIDTH:0] ESC_LIMIT =
        (PROD_WIDTH + 1)'(1) << (2 * FRAC_BITS + 2);

    localparam logic signed [COORD_WIDTH-1:0] COORD_MAX =
        {1'b0, {(COORD_WIDTH - 1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] COORD_MIN =
        {1'b1, {(COORD_WIDTH - 1){1'b0}}};

    typedef logic signed [COORD_WIDTH-1:0]  t_coord;
    typedef logic signed [PROD_WIDTH-1:0]   t_prod;
    typedef logic signed [PROD_WIDTH+1:0]   t_wide;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] c_real;
        logic signed [COORD_WIDTH-1:0] c_imag;
    } t_in_req;

    typedef struct packed {
        logic                 in_set;
        logic [CNT_WIDTH-1:0] escape_count;
        logic [COL_WIDTH-1:0] red;
        logic [COL_WIDTH-1:0] green;
        logic [COL_WIDTH-1:0] blue;
    } t_out_rsp;

    typedef struct packed {
        logic                 in_set;
        logic [CNT_WIDTH-1:0] escape_count;
    } t_iter_res;

    typedef struct packed {
        logic busy;
        logic done;
    } t_iter_stat;

    typedef struct packed {
        logic [COL_WIDTH-1:0] red;
        logic [COL_WIDTH-1:0] green;
        logic [COL_WIDTH-1:0] blue;
    } t_rgb;

    // clamp a wide signed sum to the coordinate range
    function automatic t_coord sat_coord(t_wide v);
        logic [PROD_WIDTH-COORD_WIDTH+2:0] top;
        t_coord                            res;
        top = v[PROD_WIDTH+1:COORD_WIDTH-1];
        if ((&top) || !(|top)) begin
            res = v[COORD_WIDTH-1:0];
        end else if (v[PROD_WIDTH+1]) begin
            res = COORD_MIN;
        end else begin
            res = COORD_MAX;
        end
        return res;
    endfunction

    // piecewise red-blue-green-red gradient
    function automatic t_rgb colour_map(logic in_set, logic [CNT_WIDTH-1:0] cnt);
        t_rgb        c;
        logic [10:0] n;
        c = '0;
        n = 11'(cnt);
        if (in_set) begin
            c = '0;
        end else if (cnt == '0) begin
            c.red = 8'd255;
        end else if (cnt inside {[7'd1:7'd15]}) begin
            c.red  = 8'(11'd256 - (n << 4));
            c.blue = 8'((n << 4) - 11'd1);
        end else if (cnt inside {[7'd16:7'd31]}) begin
            c.green = 8'((n - 11'd16) << 4);
            c.blue  = 8'(11'd512 - (n << 4) - 11'd1);
        end else if (cnt inside {[7'd32:7'd63]}) begin
            c.red   = 8'((n - 11'd32) << 3);
            c.green = 8'(11'd512 - (n << 3) - 11'd1);
        end else begin
            c.red = 8'(11'd255 - ((n - 11'd64) << 2));
        end
        return c;
    endfunction

endpackage

[src/met_mul.sv]
// ----------------------------------------------------------------------------
// met_mul
// shared signed coordinate multiplier with registered product
// ----------------------------------------------------------------------------
module met_mul
    import met_pkg::*;
(
    input  logic   i_clk,
    input  t_coord i_a,
    input  t_coord i_b,
    output t_prod  o_p
);

    t_prod r_p;
    t_prod n_p;

    assign n_p = t_prod'(i_a) * t_prod'(i_b);

    always_ff @(posedge i_clk) begin
        r_p <= n_p;
    end

    assign o_p = r_p;

endmodule

[src/met_iter.sv]
// ----------------------------------------------------------------------------
// met_iter
// escape time sequencer: runs z = z*z + c on the shared multiplier
// ----------------------------------------------------------------------------
`include "mandelbrot_escape_time_colour_assert.svh"

module met_iter
    import met_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  t_in_req              i_c,
    input  logic [CNT_WIDTH-1:0] i_max_iter,
    input  logic                 i_take,
    output t_iter_stat           o_stat,
    output t_iter_res            o_res
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_TEST = 3'd1;
    localparam logic [2:0] S_SQR  = 3'd2;
    localparam logic [2:0] S_SQI  = 3'd3;
    localparam logic [2:0] S_CRS  = 3'd4;
    localparam logic [2:0] S_UPD  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]                r_state;
    logic [CNT_WIDTH-1:0]      r_n;
    logic                      r_in_set;
    logic [CNT_WIDTH-1:0]      r_count;
    t_coord                    r_cr;
    t_coord                    r_ci;
    t_coord                    r_zr;
    t_coord                    r_zi;
    t_prod                     r_sr;
    logic [PROD_WIDTH:0]       r_mag;
    logic signed [PROD_WIDTH:0] r_dr;

    t_coord mul_a;
    t_coord mul_b;
    t_prod  w_p;
    t_wide  re_sum;
    t_wide  im_sum;
    t_coord n_zr;
    t_coord n_zi;
    logic   escape;
    logic   repeat_hit;

    met_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (w_p)
    );

    always_comb begin
        case (r_state)
            S_SQR: begin
                mul_a = r_zr;
                mul_b = r_zr;
            end
            S_SQI: begin
                mul_a = r_zi;
                mul_b = r_zi;
            end
            default: begin
                mul_a = r_zr;
                mul_b = r_zi;
            end
        endcase
    end

    assign re_sum     = t_wide'(r_dr >>> FRAC_BITS) + t_wide'(r_cr);
    assign im_sum     = t_wide'(w_p >>> (FRAC_BITS - 1)) + t_wide'(r_ci);
    assign n_zr       = sat_coord(re_sum);
    assign n_zi       = sat_coord(im_sum);
    assign escape     = r_mag > ESC_LIMIT;
    assign repeat_hit = (n_zr == r_cr) && (n_zi == r_ci);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_n      <= '0;
            r_in_set <= 1'b0;
            r_count  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_n     <= '0;
                        r_state <= S_TEST;
                    end
                end
                S_TEST: begin
                    if (r_n >= i_max_iter) begin
                        r_in_set <= 1'b1;
                        r_count  <= '0;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_SQR;
                    end
                end
                S_SQR: begin
                    r_state <= S_SQI;
                end
                S_SQI: begin
                    r_state <= S_CRS;
                end
                S_CRS: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (escape) begin
                        r_in_set <= 1'b0;
                        r_count  <= r_n;
                        r_state  <= S_DONE;
                    end else if (repeat_hit) begin
                        r_in_set <= 1'b1;
                        r_count  <= '0;
                        r_state  <= S_DONE;
                    end else begin
                        r_n     <= r_n + 1'b1;
                        r_state <= S_TEST;
                    end
                end
                S_DONE: begin
                    if (i_take) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_cr <= i_c.c_real;
            r_ci <= i_c.c_imag;
            r_zr <= i_c.c_real;
            r_zi <= i_c.c_imag;
        end else if (r_state == S_UPD) begin
            r_zr <= n_zr;
            r_zi <= n_zi;
        end
        if (r_state == S_SQI) begin
            r_sr <= w_p;
        end
        if (r_state == S_CRS) begin
            r_mag <= (PROD_WIDTH + 1)'($unsigned(r_sr)) + (PROD_WIDTH + 1)'($unsigned(w_p));
            r_dr  <= (PROD_WIDTH + 1)'(r_sr) - (PROD_WIDTH + 1)'(w_p);
        end
    end

    assign o_stat.busy       = (r_state != S_IDLE);
    assign o_stat.done       = (r_state == S_DONE);
    assign o_res.in_set      = r_in_set;
    assign o_res.escape_count = r_count;

    `MET_ASSERT_IMP(a_start_idle, i_start, r_state == S_IDLE, "start while busy")
    `MET_ASSERT_IMP(a_inset_zero, r_state == S_DONE && r_in_set, r_count == '0,
        "in-set result with nonzero count")
    `MET_ASSERT_NXT(a_upd_next, r_state == S_UPD,
        r_state == S_TEST || r_state == S_DONE, "bad state after update")
    `MET_ASSERT_NXT(a_done_hold, r_state == S_DONE && !i_take,
        r_state == S_DONE && $stable(r_count) && $stable(r_in_set),
        "result lost before take")

endmodule

[src/mandelbrot_escape_time_colour.sv]
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_colour
// escape time evaluation of one complex point with gradient colour output
// ----------------------------------------------------------------------------
// usage:
//  input channel i_in_valid / o_in_stall / i_in_data carries one point c
//  (Q3.28 real and imaginary parts); a request is taken when valid is high
//  and stall is low. output channel o_out_valid / i_out_stall / o_out_data
//  carries in_set, escape_count and the red, green, blue colour.
//  i_cfg_we / i_cfg_data write the iteration limit max_iter; the user must
//  write it only when idle, which the block does not enforce. each iteration
//  steps through test, two squares, cross product and update on the one
//  shared 32x32 multiplier; a point ends when it escapes, when it returns to
//  c, or when it reaches the limit max_iter (127 after reset).
//  one point is in flight at a time; o_in_stall is high while it runs and
//  drops as its result moves into the output register.
//  a finished point holds in the sequencer until the output register is free.
//  reset (synchronous, active low) empties the block and sets max_iter 127.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_colour
    import met_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_req              i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_rsp             o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CNT_WIDTH-1:0] i_cfg_data
);

    logic [CNT_WIDTH-1:0] r_max_iter;
    logic                 r_out_valid;
    t_out_rsp             r_out_data;
    t_out_rsp             n_out_data;

    t_iter_stat stat;
    t_iter_res  res;
    t_rgb       rgb;
    logic       start;
    logic       take;

    assign start = i_in_valid && !stat.busy;
    assign take  = stat.done && (!r_out_valid || !i_out_stall);

    met_iter u_iter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_c        (i_in_data),
        .i_max_iter (r_max_iter),
        .i_take     (take),
        .o_stat     (stat),
        .o_res      (res)
    );

    assign rgb = colour_map(res.in_set, res.escape_count);

    always_comb begin
        n_out_data.in_set       = res.in_set;
        n_out_data.escape_count = res.escape_count;
        n_out_data.red          = rgb.red;
        n_out_data.green        = rgb.green;
        n_out_data.blue         = rgb.blue;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iter  <= MAX_ITER_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_iter <= i_cfg_data;
            end
            if (take) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_in_stall  = stat.busy;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
